/* rtl/core/slum_pkg.sv */
// ----------------------------------------------------------------------------
// slum_pkg: shared types and constants for the sorted list union merge
// Opcodes, result codes, beat structs and controller/datapath handshake.
// ----------------------------------------------------------------------------
package slum_pkg;

	localparam int unsigned LISTS_DEF      = 8;
	localparam int unsigned LIST_DEPTH_DEF = 32;
	localparam int unsigned STATE_BITS_DEF = 16;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_PULL   = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_ACCEPTED  = 2'd0,
		ST_EMITTED   = 2'd1,
		ST_EXHAUSTED = 2'd2,
		ST_REJECTED  = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [2:0]  list_index;
		logic [15:0] value;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] merged_value;
		logic        last_value;
	} out_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_ADV,
		S_LOAD,
		S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic exec_imm;   // run clear/append/no-op on the accepted beat
		logic pull_init;  // start a pull: drop found and any-left flags
		logic scan;       // compare head of current list against best
		logic adv;        // advance current list if its head equals best
		logic load;       // refill head register from memory
		logic out_pull;   // write pull result into output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic found;
		logic match;
		logic more;
		logic out_free;
	} stat_t;

endpackage

/* rtl/core/slum_ctrl.sv */
// ----------------------------------------------------------------------------
// slum_ctrl: sequencer for the sorted list union merge
// Accepts beats, steps a list counter through scan, advance and head reload.
// ----------------------------------------------------------------------------
module slum_ctrl #(
	parameter int unsigned LISTS = slum_pkg::LISTS_DEF,
	localparam int unsigned LW   = $clog2(LISTS)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     opcode,
	input  slum_pkg::stat_t st,
	output slum_pkg::cmd_t  cmd,
	output logic [LW-1:0]  cnt
);

	slum_pkg::state_t state_q, state_d;
	logic [LW-1:0] cnt_q, cnt_d;
	logic          cnt_last;

	assign cnt_last = (cnt_q == LW'(LISTS - 1));
	assign cnt      = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slum_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			slum_pkg::S_IDLE: begin
				in_ready = st.out_free;
				if (in_valid && st.out_free) begin
					if (opcode == slum_pkg::OP_PULL) begin
						cmd.pull_init = 1'b1;
						cnt_d         = '0;
						state_d       = slum_pkg::S_SCAN;
					end else begin
						cmd.exec_imm = 1'b1;
					end
				end
			end
			slum_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_last) begin
					cnt_d   = '0;
					state_d = slum_pkg::S_ADV;
				end
			end
			slum_pkg::S_ADV: begin
				if (!st.found) begin
					state_d = slum_pkg::S_DONE;
				end else begin
					cmd.adv = 1'b1;
					if (st.match && st.more) begin
						state_d = slum_pkg::S_LOAD;
					end else if (cnt_last) begin
						state_d = slum_pkg::S_DONE;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			slum_pkg::S_LOAD: begin
				cmd.load = 1'b1;
				if (cnt_last) begin
					state_d = slum_pkg::S_DONE;
				end else begin
					cnt_d   = cnt_q + 1'b1;
					state_d = slum_pkg::S_ADV;
				end
			end
			slum_pkg::S_DONE: begin
				if (st.out_free) begin
					cmd.out_pull = 1'b1;
					state_d      = slum_pkg::S_IDLE;
				end
			end
			default: state_d = slum_pkg::S_IDLE;
		endcase
	end

	a_load_after_adv: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == slum_pkg::S_LOAD |-> $past(state_q) == slum_pkg::S_ADV)
		else $error("head reload without advance");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == slum_pkg::S_IDLE)
		else $error("ready outside idle");
	a_pull_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_pull |-> st.out_free)
		else $error("pull result into busy output register");

endmodule

/* rtl/core/slum_dp.sv */
// ----------------------------------------------------------------------------
// slum_dp: list storage, head registers, best tracker and output register
// ----------------------------------------------------------------------------
module slum_dp #(
	parameter int unsigned LISTS      = slum_pkg::LISTS_DEF,
	parameter int unsigned LIST_DEPTH = slum_pkg::LIST_DEPTH_DEF,
	parameter int unsigned STATE_BITS = slum_pkg::STATE_BITS_DEF,
	localparam int unsigned LW = $clog2(LISTS),
	localparam int unsigned PW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
	localparam int unsigned CW = $clog2(LIST_DEPTH + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  slum_pkg::cmd_t  cmd,
	input  logic [LW-1:0]   cnt,
	input  slum_pkg::in_t   in_data,
	output slum_pkg::stat_t st,
	output logic            out_valid,
	input  logic            out_ready,
	output slum_pkg::out_t  out_data
);

	logic [STATE_BITS-1:0] mem [LISTS << PW];
	logic [STATE_BITS-1:0] rdata_q;

	logic [CW-1:0]         fill_q [LISTS];
	logic [CW-1:0]         rpos_q [LISTS];
	logic [STATE_BITS-1:0] tail_q [LISTS];
	logic [STATE_BITS-1:0] head_q [LISTS];

	logic [STATE_BITS-1:0] best_q;
	logic                  found_q, any_q;
	logic                  ovalid_q;
	slum_pkg::out_t        out_q;

	logic [STATE_BITS-1:0] val_m;
	logic                  idx_ok;
	logic [LW-1:0]         sel;
	logic                  app_ok;
	logic                  cur_ne;
	logic [CW-1:0]         rpos_nx;

	assign val_m   = STATE_BITS'(in_data.value);
	assign idx_ok  = 32'(in_data.list_index) < 32'(LISTS);
	assign sel     = LW'(in_data.list_index);
	assign app_ok  = idx_ok && (32'(fill_q[sel]) < 32'(LIST_DEPTH))
		&& (fill_q[sel] == '0 || val_m > tail_q[sel]);
	assign cur_ne  = rpos_q[cnt] < fill_q[cnt];
	assign rpos_nx = rpos_q[cnt] + 1'b1;

	assign st.found    = found_q;
	assign st.match    = cur_ne && head_q[cnt] == best_q;
	assign st.more     = rpos_nx < fill_q[cnt];
	assign st.out_free = !ovalid_q || out_ready;

	assign out_valid = ovalid_q;
	assign out_data  = out_q;

	// list memory: append writes, head refill reads
	always_ff @(posedge clk) begin
		if (cmd.exec_imm && in_data.opcode == slum_pkg::OP_APPEND && app_ok) begin
			mem[{sel, fill_q[sel][PW-1:0]}] <= val_m;
		end
		if (cmd.adv) begin
			rdata_q <= mem[{cnt, rpos_nx[PW-1:0]}];
		end
	end

	// head registers need no reset: an empty list never offers its head
	always_ff @(posedge clk) begin
		if (cmd.exec_imm && in_data.opcode == slum_pkg::OP_APPEND && app_ok
			&& rpos_q[sel] == fill_q[sel]) begin
			head_q[sel] <= val_m;
		end
		if (cmd.load) begin
			head_q[cnt] <= rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LISTS; k++) begin
				fill_q[k] <= '0;
				rpos_q[k] <= '0;
				tail_q[k] <= '0;
			end
		end else if (cmd.exec_imm) begin
			case (in_data.opcode)
				slum_pkg::OP_CLEAR: begin
					for (int k = 0; k < LISTS; k++) begin
						fill_q[k] <= '0;
						rpos_q[k] <= '0;
						tail_q[k] <= '0;
					end
				end
				slum_pkg::OP_APPEND: begin
					if (app_ok) begin
						fill_q[sel] <= fill_q[sel] + 1'b1;
						tail_q[sel] <= val_m;
					end
				end
				default: ;
			endcase
		end else if (cmd.adv && st.match) begin
			rpos_q[cnt] <= rpos_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			any_q   <= 1'b0;
			best_q  <= '0;
		end else if (cmd.pull_init) begin
			found_q <= 1'b0;
			any_q   <= 1'b0;
		end else if (cmd.scan) begin
			if (cur_ne && (!found_q || head_q[cnt] < best_q)) begin
				best_q  <= head_q[cnt];
				found_q <= 1'b1;
			end
		end else if (cmd.adv) begin
			if (st.match ? st.more : cur_ne) begin
				any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.exec_imm || cmd.out_pull) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec_imm) begin
			out_q.merged_value <= '0;
			out_q.last_value   <= 1'b0;
			out_q.status       <= (in_data.opcode == slum_pkg::OP_APPEND && !app_ok)
				? slum_pkg::ST_REJECTED : slum_pkg::ST_ACCEPTED;
		end else if (cmd.out_pull) begin
			out_q.status       <= found_q ? slum_pkg::ST_EMITTED : slum_pkg::ST_EXHAUSTED;
			out_q.merged_value <= found_q ? 16'(best_q) : 16'd0;
			out_q.last_value   <= found_q && !any_q;
		end
	end

	a_adv_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.adv && st.match |=> found_q)
		else $error("advance without a best value");
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.exec_imm, cmd.scan, cmd.adv, cmd.load, cmd.out_pull}))
		else $error("overlapping datapath commands");
	a_load_data: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> $past(cmd.adv && st.match && st.more))
		else $error("head reload without memory read");

endmodule

/* rtl/core/sorted_list_union_merge.sv */
// ----------------------------------------------------------------------------
// sorted_list_union_merge: ascending union of several sorted lists, no dups
// Append values to per-list buffers, pull the merged stream one beat at a time.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  in      | in  | in_valid/in_ready   | in_data  (opcode, list_index, value)
//  out     | out | out_valid/out_ready | out_data (status, merged_value, last_value)
//
//  Clear, append and unused opcodes: result beat registered at the accepting
//  edge, so it is offered from the following cycle.
//  Pull: a scan step per list, then an advance step per list plus a head
//  reload step per list that moves on, then the result is posted once the
//  output register is free. With all lists empty the advance phase ends at
//  once. Steps run one after another through the shared compare unit and
//  the single read port of the list memory.
//  Reset clears fills, read pointers and last values; memory is not cleared.
//  A stalled output holds its beat; input ready drops while a pull runs
//  or while the output register is full and not being taken.
// ----------------------------------------------------------------------------
module sorted_list_union_merge #(
	parameter int unsigned LISTS      = slum_pkg::LISTS_DEF,
	parameter int unsigned LIST_DEPTH = slum_pkg::LIST_DEPTH_DEF,
	parameter int unsigned STATE_BITS = slum_pkg::STATE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  slum_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output slum_pkg::out_t out_data
);

	localparam int unsigned LW = $clog2(LISTS);

	slum_pkg::cmd_t  cmd;
	slum_pkg::stat_t st;
	logic [LW-1:0]   cnt;

	// sequencer: owns the list counter and the pull phases
	slum_ctrl #(
		.LISTS (LISTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (in_data.opcode),
		.st       (st),
		.cmd      (cmd),
		.cnt      (cnt)
	);

	// datapath: buffers, heads, best tracking and the output beat register
	slum_dp #(
		.LISTS      (LISTS),
		.LIST_DEPTH (LIST_DEPTH),
		.STATE_BITS (STATE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cnt       (cnt),
		.in_data   (in_data),
		.st        (st),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
